[design/lctcs_pkg.sv]
// Shared types and constants of the load cell tare/calibrate/scale unit.
// Used by lctcs_serial_div and load_cell_tare_calibrate_scale_unit; no dependencies.
package lctcs_pkg;

   localparam int CODE_W    = 24;
   localparam int DIFF_W    = 25;
   localparam int SUM_W     = 34;
   localparam int COUNT_W   = 8;
   localparam int FACTOR_W  = 41;
   localparam int WEIGHT_W  = 48;
   localparam int REFW_W    = 16;
   localparam int DEN_W     = 24;
   localparam int DVD_W     = 57;
   localparam int DVS_W     = 41;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   localparam int DEF_TARE_SAMPLES = 16;
   localparam int DEF_CAL_SAMPLES  = 16;

   localparam logic [CODE_W-1:0] SIGN_FLIP = 24'h800000;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_WGT = 1'b1;

   localparam logic [1:0] MODE_MEASURE = 2'd0;
   localparam logic [1:0] MODE_TARE    = 2'd1;
   localparam logic [1:0] MODE_CAL     = 2'd2;
   localparam logic [1:0] MODE_NONE    = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[design/lctcs_serial_div.sv]
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on lctcs_pkg for operand widths and the status struct.
module lctcs_serial_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lctcs_pkg::DVD_W-1:0]   dividend,
   input  logic [lctcs_pkg::DVS_W-1:0]   divisor,
   output logic [lctcs_pkg::DVD_W-1:0]   quotient,
   output lctcs_pkg::div_status_type     status
);
   import lctcs_pkg::*;

   localparam int CNT_W = $clog2(DVD_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

   logic [DVD_W-1:0] shift_ff, shift_in;
   logic [DVS_W-1:0] divisor_ff, divisor_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   trial_diff;

   assign trial      = {rem_ff, shift_ff[DVD_W-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};

   always_comb begin
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         shift_in   = dividend;
         divisor_in = divisor;
         rem_in     = '0;
         step_in    = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         if (!trial_diff[DVS_W]) begin
            rem_in   = trial_diff[DVS_W-1:0];
            shift_in = {shift_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in   = trial[DVS_W-1:0];
            shift_in = {shift_ff[DVD_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      step_ff    <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = shift_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[design/load_cell_tare_calibrate_scale_unit.sv]
// Top level of the load cell tare/calibrate/scale unit.
// Depends on lctcs_pkg and lctcs_serial_div.
//
//   channel  direction  ports
//   req      in         req_valid req_ready req_sample_code
//   rsp      out        rsp_valid rsp_ready rsp_weight_value rsp_batch_done rsp_range_error
//   csr      in         csr_valid csr_ready csr_index csr_wdata
//
// A sample that only adds to a batch keeps the unit idle. A measure sample, and the sample
// that ends a batch, go through S_DIV, where the divider takes 57 one-bit steps, then S_FINISH.
// A measure with a zero factor, or a batch end with a zero reference weight, skips S_DIV.
// Reset is synchronous; csr_ready is always high. A stalled rsp holds the result register
// and the next sample is taken meanwhile, but its result waits until the register is free.
module load_cell_tare_calibrate_scale_unit #(
   parameter int TARE_SAMPLES = lctcs_pkg::DEF_TARE_SAMPLES,
   parameter int CAL_SAMPLES  = lctcs_pkg::DEF_CAL_SAMPLES
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [lctcs_pkg::CODE_W-1:0]          req_sample_code,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [lctcs_pkg::WEIGHT_W-1:0] rsp_weight_value,
   output logic                                  rsp_batch_done,
   output logic                                  rsp_range_error,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lctcs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lctcs_pkg::CSR_DAT_W-1:0]       csr_wdata
);
   import lctcs_pkg::*;

   localparam logic [COUNT_W-1:0] TARE_N =
      (TARE_SAMPLES == 0) ? COUNT_W'(1) : COUNT_W'(TARE_SAMPLES);
   localparam logic [COUNT_W-1:0] CAL_N =
      (CAL_SAMPLES == 0) ? COUNT_W'(1) : COUNT_W'(CAL_SAMPLES);

   localparam logic signed [WEIGHT_W-1:0] OUT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
   localparam logic signed [WEIGHT_W-1:0] OUT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};
   localparam logic signed [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(65536);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_DIV    = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   typedef enum logic [2:0] {
      OP_MEAS,
      OP_ZERO_FACTOR,
      OP_TARE,
      OP_CAL,
      OP_REF_ERR
   } op_type;

   state_type                    state_ff, state_in;
   op_type                       op_ff, op_in;
   logic [1:0]                   mode_ff, mode_in;
   logic [REFW_W-1:0]            refw_ff, refw_in;
   logic [CODE_W-1:0]            tare_ff, tare_in;
   logic signed [FACTOR_W-1:0]   factor_ff, factor_in;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic [COUNT_W-1:0]           count_ff, count_in;
   logic                         neg_ff, neg_in;
   logic                         zero_ff, zero_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [WEIGHT_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                         rsp_done_ff, rsp_done_in;
   logic                         rsp_err_ff, rsp_err_in;

   logic                         accept;
   logic                         out_free;
   logic [DEN_W-1:0]             den;
   logic [CODE_W-1:0]            offset_code;
   logic signed [DIFF_W-1:0]     diff;
   logic [CODE_W-1:0]            diff_mag;
   logic [DVS_W-1:0]             factor_mag;
   logic signed [SUM_W-1:0]      sum_tare;
   logic signed [SUM_W-1:0]      sum_cal;
   logic [SUM_W-1:0]             sum_cal_mag;
   logic [COUNT_W-1:0]           count_next;

   logic                         div_start;
   logic [DVD_W-1:0]             div_dividend;
   logic [DVS_W-1:0]             div_divisor;
   logic [DVD_W-1:0]             div_quotient;
   div_status_type               div_status;

   logic                         pos_ovf;
   logic                         neg_ovf;
   logic [WEIGHT_W-1:0]          q_low;

   lctcs_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign den         = DEN_W'(refw_ff) * DEN_W'(CAL_N);
   assign offset_code = req_sample_code ^ SIGN_FLIP;
   assign diff        = $signed({1'b0, offset_code}) - $signed({1'b0, tare_ff});
   assign diff_mag    = diff[DIFF_W-1] ? CODE_W'(-diff) : diff[CODE_W-1:0];
   assign factor_mag  = factor_ff[FACTOR_W-1] ? DVS_W'(-factor_ff) : DVS_W'(factor_ff);
   assign sum_tare    = sum_ff + $signed({{(SUM_W-CODE_W){1'b0}}, offset_code});
   assign sum_cal     = sum_ff + SUM_W'(diff);
   assign sum_cal_mag = sum_cal[SUM_W-1] ? SUM_W'(-sum_cal) : SUM_W'(sum_cal);
   assign count_next  = count_ff + 1'b1;

   assign q_low   = div_quotient[WEIGHT_W-1:0];
   assign pos_ovf = |div_quotient[DVD_W-1:WEIGHT_W-1];
   assign neg_ovf = (|div_quotient[DVD_W-1:WEIGHT_W])
                    || (div_quotient[WEIGHT_W-1] && (|div_quotient[WEIGHT_W-2:0]));

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      mode_in      = mode_ff;
      refw_in      = refw_ff;
      tare_in      = tare_ff;
      factor_in    = factor_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_err_in   = rsp_err_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE: begin
               mode_in  = csr_wdata[1:0];
               sum_in   = '0;
               count_in = '0;
            end
            CSR_REF_WGT: refw_in = csr_wdata[REFW_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (mode_ff)
                  MODE_MEASURE: begin
                     neg_in  = diff[DIFF_W-1] ^ factor_ff[FACTOR_W-1];
                     zero_in = (diff == '0);
                     if (factor_ff == '0) begin
                        neg_in   = diff[DIFF_W-1];
                        op_in    = OP_ZERO_FACTOR;
                        state_in = S_FINISH;
                     end else begin
                        div_start    = 1'b1;
                        div_dividend = {1'b0, diff_mag, 32'd0};
                        div_divisor  = factor_mag;
                        op_in        = OP_MEAS;
                        state_in     = S_DIV;
                     end
                  end
                  MODE_TARE: begin
                     sum_in   = sum_tare;
                     count_in = count_next;
                     if (count_next >= TARE_N) begin
                        div_start    = 1'b1;
                        div_dividend = {{(DVD_W-SUM_W){1'b0}}, sum_tare};
                        div_divisor  = {{(DVS_W-COUNT_W){1'b0}}, TARE_N};
                        sum_in       = '0;
                        count_in     = '0;
                        mode_in      = MODE_MEASURE;
                        op_in        = OP_TARE;
                        state_in     = S_DIV;
                     end
                  end
                  MODE_CAL: begin
                     sum_in   = sum_cal;
                     count_in = count_next;
                     if (count_next >= CAL_N) begin
                        sum_in   = '0;
                        count_in = '0;
                        mode_in  = MODE_MEASURE;
                        neg_in   = sum_cal[SUM_W-1];
                        if (refw_ff == '0) begin
                           op_in    = OP_REF_ERR;
                           state_in = S_FINISH;
                        end else begin
                           div_start    = 1'b1;
                           div_dividend = {{(DVD_W-SUM_W-16){1'b0}}, sum_cal_mag, 16'd0};
                           div_divisor  = {{(DVS_W-DEN_W){1'b0}}, den};
                           op_in        = OP_CAL;
                           state_in     = S_DIV;
                        end
                     end
                  end
                  MODE_NONE: ;
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_done_in  = 1'b0;
               rsp_err_in   = 1'b0;
               state_in     = S_IDLE;
               unique case (op_ff)
                  OP_MEAS: begin
                     if (!neg_ff) begin
                        rsp_value_in = pos_ovf ? OUT_MAX : $signed(q_low);
                        rsp_err_in   = pos_ovf;
                     end else begin
                        rsp_value_in = neg_ovf ? OUT_MIN : $signed(WEIGHT_W'(0) - q_low);
                        rsp_err_in   = neg_ovf;
                     end
                  end
                  OP_ZERO_FACTOR: begin
                     rsp_err_in = 1'b1;
                     if (zero_ff) begin
                        rsp_value_in = '0;
                     end else begin
                        rsp_value_in = neg_ff ? OUT_MIN : OUT_MAX;
                     end
                  end
                  OP_TARE: begin
                     rsp_done_in = 1'b1;
                     tare_in     = div_quotient[CODE_W-1:0];
                  end
                  OP_CAL: begin
                     rsp_done_in = 1'b1;
                     factor_in   = neg_ff ? $signed(FACTOR_W'(0) - div_quotient[FACTOR_W-1:0])
                                          : $signed(div_quotient[FACTOR_W-1:0]);
                  end
                  OP_REF_ERR: begin
                     rsp_done_in = 1'b1;
                     rsp_err_in  = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      neg_ff       <= neg_in;
      zero_ff      <= zero_in;
      rsp_value_ff <= rsp_value_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_err_ff   <= rsp_err_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_MEASURE;
         refw_ff      <= REFW_W'(1);
         tare_ff      <= '0;
         factor_ff    <= FACTOR_ONE;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         refw_ff      <= refw_in;
         tare_ff      <= tare_in;
         factor_ff    <= factor_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_weight_value = rsp_value_ff;
   assign rsp_batch_done   = rsp_done_ff;
   assign rsp_range_error  = rsp_err_ff;

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> (state_ff == S_DIV))
      else $error("divider busy outside the divide state");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished transaction not placed in the result register");

   a_rsp_rise_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result raised outside the finish state");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff < TARE_N) || (count_ff < CAL_N))
      else $error("batch count beyond batch length");

endmodule
